### rtl/sle_pkg.sv
// shared constants and handshake structs for the sequential list engine
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int ACT_W    = 3;
	localparam int STS_W    = 3;

	localparam logic [ACT_W-1:0] A_PUSH_BACK  = 3'd0;
	localparam logic [ACT_W-1:0] A_POP_BACK   = 3'd1;
	localparam logic [ACT_W-1:0] A_PUSH_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] A_POP_FRONT  = 3'd3;
	localparam logic [ACT_W-1:0] A_INSERT     = 3'd4;
	localparam logic [ACT_W-1:0] A_ERASE      = 3'd5;
	localparam logic [ACT_W-1:0] A_FIND       = 3'd6;
	localparam logic [ACT_W-1:0] A_REMOVE     = 3'd7;

	localparam logic [STS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STS_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

### rtl/sle_seq.sv
// list store and command sequencer: one entry read and one written per cycle
module sle_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sle_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output sle_pkg::res_t res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_DN   = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [sle_pkg::CNT_W-1:0] CAP_C = sle_pkg::CNT_W'(sle_pkg::CAPACITY);
	localparam logic [sle_pkg::CNT_W-1:0] ONE_C = sle_pkg::CNT_W'(1);
	localparam logic [sle_pkg::IDX_W-1:0] ONE_I = sle_pkg::IDX_W'(1);

	logic [sle_pkg::VAL_W-1:0] mem [sle_pkg::CAPACITY];

	logic [2:0]                state_q, state_d;
	logic [sle_pkg::CNT_W-1:0] count_q, count_d;
	logic [sle_pkg::CNT_W-1:0] ptr_q, ptr_d;
	logic                      issue_q, issue_d;
	logic [sle_pkg::ACT_W-1:0] act_q, act_d;
	logic [sle_pkg::VAL_W-1:0] val_q, val_d;
	logic [sle_pkg::IDX_W-1:0] at_q, at_d;
	logic [sle_pkg::IDX_W-1:0] fidx_q, fidx_d;
	sle_pkg::res_t             res_q, res_d;
	logic                      vld_s1, vld_d;
	logic [sle_pkg::IDX_W-1:0] addr_s1, addr_d;
	logic [sle_pkg::VAL_W-1:0] rdata_s1;

	logic                      we, re;
	logic [sle_pkg::IDX_W-1:0] waddr, raddr;
	logic [sle_pkg::VAL_W-1:0] wdata;
	logic                      full, empty;
	logic [sle_pkg::CNT_W-1:0] pos_ext, at_ext, cnt_m1;

	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign pos_ext   = sle_pkg::CNT_W'(cmd.position);
	assign at_ext    = sle_pkg::CNT_W'(at_q);
	assign cnt_m1    = count_q - ONE_C;
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d   = ptr_q;
		issue_d = issue_q;
		act_d   = act_q;
		val_d   = val_q;
		at_d    = at_q;
		fidx_d  = fidx_q;
		res_d   = res_q;
		vld_d   = 1'b0;
		addr_d  = addr_s1;
		we      = 1'b0;
		waddr   = '0;
		wdata   = val_q;
		re      = 1'b0;
		raddr   = ptr_q[sle_pkg::IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					act_d  = cmd.action;
					val_d  = cmd.value;
					fidx_d = '0;
					res_d.found_index = '0;
					res_d.status      = sle_pkg::ST_OK;
					state_d           = S_FIN;
					unique case (cmd.action) inside
						sle_pkg::A_PUSH_BACK: begin
							if (full) begin
								res_d.status = sle_pkg::ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = count_q[sle_pkg::IDX_W-1:0];
								wdata   = cmd.value;
								count_d = count_q + ONE_C;
							end
						end
						sle_pkg::A_POP_BACK: begin
							if (empty) res_d.status = sle_pkg::ST_EMPTY;
							else count_d = cnt_m1;
						end
						sle_pkg::A_PUSH_FRONT, sle_pkg::A_INSERT: begin
							if (full) begin
								res_d.status = sle_pkg::ST_FULL;
							end else if (cmd.action == sle_pkg::A_INSERT
									&& pos_ext > count_q) begin
								res_d.status = sle_pkg::ST_BADPOS;
							end else begin
								// move entries up from the back, then drop the new word in
								at_d    = (cmd.action == sle_pkg::A_INSERT) ? cmd.position : '0;
								ptr_d   = cnt_m1;
								issue_d = (cmd.action == sle_pkg::A_INSERT)
								          ? (pos_ext != count_q) : !empty;
								state_d = S_UP;
							end
						end
						sle_pkg::A_POP_FRONT, sle_pkg::A_ERASE: begin
							if (empty) begin
								res_d.status = sle_pkg::ST_EMPTY;
							end else if (cmd.action == sle_pkg::A_ERASE
									&& pos_ext >= count_q) begin
								res_d.status = sle_pkg::ST_BADPOS;
							end else begin
								at_d    = (cmd.action == sle_pkg::A_ERASE) ? cmd.position : '0;
								ptr_d   = ((cmd.action == sle_pkg::A_ERASE) ? pos_ext : '0)
								          + ONE_C;
								issue_d = (((cmd.action == sle_pkg::A_ERASE) ? pos_ext : '0)
								          + ONE_C) != count_q;
								state_d = S_DN;
							end
						end
						sle_pkg::A_FIND, sle_pkg::A_REMOVE: begin
							if (empty) begin
								res_d.status = sle_pkg::ST_NOTFOUND;
							end else begin
								ptr_d   = '0;
								issue_d = 1'b1;
								state_d = S_SRCH;
							end
						end
						default: ;
					endcase
					res_d.count = count_d;
				end
			end
			S_UP: begin
				re     = issue_q;
				vld_d  = issue_q;
				addr_d = ptr_q[sle_pkg::IDX_W-1:0];
				if (issue_q) begin
					ptr_d = ptr_q - ONE_C;
					if (ptr_q == at_ext) issue_d = 1'b0;
				end
				if (vld_s1) begin
					we    = 1'b1;
					waddr = addr_s1 + ONE_I;
					wdata = rdata_s1;
				end else if (!issue_q) begin
					we                = 1'b1;
					waddr             = at_q;
					wdata             = val_q;
					count_d           = count_q + ONE_C;
					res_d.status      = sle_pkg::ST_OK;
					res_d.found_index = '0;
					res_d.count       = count_d;
					state_d           = S_FIN;
				end
			end
			S_DN: begin
				re     = issue_q;
				vld_d  = issue_q;
				addr_d = ptr_q[sle_pkg::IDX_W-1:0];
				if (issue_q) begin
					ptr_d = ptr_q + ONE_C;
					if (ptr_q == cnt_m1) issue_d = 1'b0;
				end
				if (vld_s1) begin
					we    = 1'b1;
					waddr = addr_s1 - ONE_I;
					wdata = rdata_s1;
				end else if (!issue_q) begin
					count_d           = cnt_m1;
					res_d.status      = sle_pkg::ST_OK;
					res_d.found_index = fidx_q;
					res_d.count       = count_d;
					state_d           = S_FIN;
				end
			end
			S_SRCH: begin
				re     = issue_q;
				vld_d  = issue_q;
				addr_d = ptr_q[sle_pkg::IDX_W-1:0];
				if (issue_q) begin
					ptr_d = ptr_q + ONE_C;
					if (ptr_q == cnt_m1) issue_d = 1'b0;
				end
				if (vld_s1) begin
					if (rdata_s1 == val_q) begin
						vld_d = 1'b0;
						if (act_q == sle_pkg::A_FIND) begin
							issue_d           = 1'b0;
							res_d.status      = sle_pkg::ST_OK;
							res_d.found_index = addr_s1;
							res_d.count       = count_q;
							state_d           = S_FIN;
						end else begin
							// remove: drop the in-flight read and close the gap at the hit
							fidx_d  = addr_s1;
							at_d    = addr_s1;
							ptr_d   = sle_pkg::CNT_W'(addr_s1) + ONE_C;
							issue_d = (sle_pkg::CNT_W'(addr_s1) + ONE_C) != count_q;
							state_d = S_DN;
						end
					end else if (!issue_q) begin
						res_d.status      = sle_pkg::ST_NOTFOUND;
						res_d.found_index = '0;
						res_d.count       = count_q;
						state_d           = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			issue_q <= issue_d;
			vld_s1  <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		act_q   <= act_d;
		val_q   <= val_d;
		at_q    <= at_d;
		fidx_q  <= fidx_d;
		res_q   <= res_d;
		addr_s1 <= addr_d;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_s1 <= mem[raddr];
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_count_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (state_q == S_FIN))
		else $error("entry count moved outside command completion");

	a_read_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> (sle_pkg::CNT_W'(raddr) < count_q))
		else $error("read beyond the end of the list");

	a_fidx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != sle_pkg::ST_OK) |-> (res.found_index == '0))
		else $error("found index set on a refused command");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("read and write hit the same entry in one cycle");

endmodule

### rtl/sequential_list_engine.sv
// top level of the sequential list engine: stream ports and result register
//
// An ordered list of up to 64 words of 32 bits kept in one on-chip RAM with
// one read and one write per cycle. One command is in work at a time; a result
// waiting in the output register does not block the next command. push_back,
// pop_back and every refused command give their result word without a pass
// over the list. push_front, insert, pop_front and erase move one entry per
// cycle through the RAM read-then-write path, shifting the entries from the
// position to the back. find scans one entry per cycle from the front and
// stops at the first match; remove adds the shift of the entries above the
// match. There is no clearing pass after reset.
module sequential_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero pad
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // found_index[5:0], count[12:6], zero pad
	output logic [2:0]  m_tuser    // status[2:0]
);

	sle_pkg::cmd_t cmd;
	sle_pkg::res_t res, out_q;
	logic          res_valid, res_ready;
	logic          out_valid_q;

	assign cmd.action   = s_tuser;
	assign cmd.value    = s_tdata[sle_pkg::VAL_W-1:0];
	assign cmd.position = s_tdata[sle_pkg::VAL_W +: sle_pkg::IDX_W];

	// output word register frees itself in the cycle it is taken
	assign res_ready = !out_valid_q || m_tready;

	sle_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.count, out_q.found_index};

endmodule
